// ===== hdl/nta_pkg.sv =====
// Shared types and constants for the neighbor table with aging.
`timescale 1ns / 1ps

package nta_pkg;

    localparam int TIME_W = 32;
    localparam int ID_W   = 16;
    localparam int OP_W   = 2;
    localparam int CHAN_W = 2;
    localparam int CNT_W  = 7;

    localparam logic [TIME_W-1:0] MAX_AGE_RST = 32'd1000;

    // Operation codes of a request
    typedef enum logic [OP_W-1:0] {
        OP_BEACON    = 2'd0,
        OP_SWEEP_CFG = 2'd1,
        OP_SWEEP_AGE = 2'd2
    } op_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE,
        ST_SWEEP,
        ST_SWEEP_END,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [ID_W-1:0]   vehicle_id;
        logic [CHAN_W-1:0] channel;
        logic [TIME_W-1:0] now_time;
        logic [TIME_W-1:0] sweep_age;
    } request_t;

    typedef struct packed {
        logic              is_new;
        logic              table_full;
        logic              interval_valid;
        logic [TIME_W-1:0] interval;
        logic [CNT_W-1:0]  occupancy_before;
        logic [CNT_W-1:0]  removed_count;
    } result_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic lookup;
        logic update;
        logic sweep_rd;
        logic finish;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic chan_ok;
        logic sweep_last;
    } status_t;

endpackage

// ===== hdl/nta_ctrl.sv =====
// Controller state machine sequencing beacons and sweeps.
`timescale 1ns / 1ps

module nta_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [nta_pkg::OP_W-1:0]  operation,
    input  nta_pkg::status_t          status,
    output logic                      busy,
    output nta_pkg::cmd_t             cmd
);
    import nta_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    case (op_t'(operation)) inside
                        OP_BEACON:
                            state_next = status.chan_ok ? ST_LOOKUP : ST_FINISH;
                        OP_SWEEP_CFG, OP_SWEEP_AGE:
                            state_next = ST_SWEEP;
                        default:
                            state_next = ST_FINISH;
                    endcase
                end
            end
            ST_LOOKUP:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            ST_SWEEP:
            begin
                cmd.sweep_rd = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = ST_SWEEP_END;
                end
            end
            ST_SWEEP_END:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

// ===== hdl/nta_dp.sv =====
// Datapath: id CAM, valid bits, stamp row memory, sweep pipeline, result.
`timescale 1ns / 1ps

module nta_dp #(
    parameter int ENTRIES  = 64,
    parameter int CHANNELS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  nta_pkg::request_t           request,
    input  nta_pkg::cmd_t               cmd,
    input  logic                        cfg_we,
    input  logic [nta_pkg::TIME_W-1:0]  cfg_wdata,
    output nta_pkg::status_t            status,
    output logic                        done,
    output nta_pkg::result_t            result
);
    import nta_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int OCC_W = $clog2(ENTRIES + 1);
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef logic [CHANNELS-1:0][TIME_W-1:0] row_t;

    // Configuration register
    logic [TIME_W-1:0] max_age_reg;

    // Table state
    logic [ENTRIES-1:0]  ev_reg;
    logic [ID_W-1:0]     id_reg [ENTRIES];
    logic [CHANNELS-1:0] sv_reg [ENTRIES];
    row_t                mem    [ENTRIES];
    logic [OCC_W-1:0]    occ_reg;

    // Request context
    request_t           req_reg;
    logic [TIME_W-1:0]  limit_reg;
    logic [ENTRIES-1:0] hit_reg;
    logic [ENTRIES-1:0] free_reg;
    logic [IDX_W-1:0]   tgt_reg;
    logic               found_reg;
    logic               room_reg;
    row_t               rd_row_reg;

    // Sweep pipeline
    logic [IDX_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   eval_idx_reg;
    logic               eval_vld_reg;

    result_t            res_reg;
    logic               done_reg;

    logic               hit_found;
    logic [IDX_W-1:0]   hit_idx;
    logic               free_found;
    logic [IDX_W-1:0]   free_idx;
    logic [IDX_W-1:0]   tgt_idx;
    logic [IDX_W-1:0]   rd_addr;
    logic [CH_W-1:0]    ch_idx;
    logic               old_sv;
    logic [TIME_W-1:0]  old_stamp;
    row_t               new_row;
    logic               wr_en;
    logic               fresh;
    logic               remove;
    logic               insert;

    // Status
    assign status.chan_ok    = ({{(32-CHAN_W){1'b0}}, request.channel} < 32'(CHANNELS));
    assign status.sweep_last = (cnt_reg == IDX_W'(ENTRIES - 1));

    // Lowest matching and lowest free entry
    always_comb
    begin
        hit_found  = 1'b0;
        hit_idx    = '0;
        free_found = 1'b0;
        free_idx   = '0;
        for (int e = ENTRIES - 1; e >= 0; e--)
        begin
            if (hit_reg[e])
            begin
                hit_found = 1'b1;
                hit_idx   = IDX_W'(e);
            end
            if (free_reg[e])
            begin
                free_found = 1'b1;
                free_idx   = IDX_W'(e);
            end
        end
    end

    assign tgt_idx = hit_found ? hit_idx : free_idx;
    assign rd_addr = cmd.sweep_rd ? cnt_reg : tgt_idx;

    // Beacon update of one channel in the row
    assign ch_idx    = CH_W'(req_reg.channel);
    assign old_sv    = sv_reg[tgt_reg][ch_idx];
    assign old_stamp = rd_row_reg[ch_idx];
    always_comb
    begin
        new_row         = rd_row_reg;
        new_row[ch_idx] = req_reg.now_time;
    end
    assign wr_en  = cmd.update && (found_reg || room_reg);
    assign insert = cmd.update && !found_reg && room_reg;

    // Sweep freshness check over the channels of one row
    always_comb
    begin
        fresh = 1'b0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (sv_reg[eval_idx_reg][c] &&
                ((req_reg.now_time - rd_row_reg[c]) <= limit_reg))
            begin
                fresh = 1'b1;
            end
        end
    end
    assign remove = eval_vld_reg && ev_reg[eval_idx_reg] && !fresh;

    // Stamp memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[tgt_reg] <= new_row;
        end
        rd_row_reg <= mem[rd_addr];
    end

    // Id storage
    always_ff @(posedge clk)
    begin
        if (insert)
        begin
            id_reg[tgt_reg] <= req_reg.vehicle_id;
        end
    end

    // Request context and lookup registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= request;
            limit_reg <= (op_t'(request.operation) == OP_SWEEP_CFG) ?
                         max_age_reg : request.sweep_age;
            for (int e = 0; e < ENTRIES; e++)
            begin
                hit_reg[e] <= ev_reg[e] && (id_reg[e] == request.vehicle_id);
            end
            free_reg <= ~ev_reg;
        end
        if (cmd.lookup)
        begin
            tgt_reg   <= tgt_idx;
            found_reg <= hit_found;
            room_reg  <= free_found;
        end
        eval_idx_reg <= cnt_reg;
        if (cmd.accept)
        begin
            res_reg <= '{occupancy_before: CNT_W'(occ_reg), default: '0};
        end
        else
        begin
            if (cmd.update)
            begin
                if (found_reg)
                begin
                    res_reg.interval_valid <= old_sv;
                    res_reg.interval       <= old_sv ? (req_reg.now_time - old_stamp) : '0;
                end
                else if (room_reg)
                begin
                    res_reg.is_new <= 1'b1;
                end
                else
                begin
                    res_reg.table_full <= 1'b1;
                end
            end
            if (remove)
            begin
                res_reg.removed_count <= res_reg.removed_count + CNT_W'(1);
            end
        end
    end

    // Control state: valid bits, occupancy, sweep counter, config, strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg       <= '0;
            for (int e = 0; e < ENTRIES; e++)
            begin
                sv_reg[e] <= '0;
            end
            occ_reg      <= '0;
            cnt_reg      <= '0;
            eval_vld_reg <= 1'b0;
            max_age_reg  <= MAX_AGE_RST;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_age_reg <= cfg_wdata;
            end
            done_reg     <= cmd.finish;
            eval_vld_reg <= cmd.sweep_rd;
            if (cmd.accept)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.sweep_rd)
            begin
                cnt_reg <= cnt_reg + IDX_W'(1);
            end
            if (cmd.update && found_reg)
            begin
                sv_reg[tgt_reg][ch_idx] <= 1'b1;
            end
            else if (insert)
            begin
                // new entry: only the beacon's channel carries a stamp
                ev_reg[tgt_reg] <= 1'b1;
                sv_reg[tgt_reg] <= CHANNELS'(1) << ch_idx;
                occ_reg         <= occ_reg + OCC_W'(1);
            end
            if (remove)
            begin
                ev_reg[eval_idx_reg] <= 1'b0;
                sv_reg[eval_idx_reg] <= '0;
                occ_reg              <= occ_reg - OCC_W'(1);
            end
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    // Occupancy counter tracks the valid bits
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(ev_reg) == 32'(occ_reg))
        else $error("occupancy counter out of step with entry valid bits");

    // Result strobe is never held high
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    // An insert and a sweep removal never coincide
    a_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
        !(insert && remove))
        else $error("insert during sweep evaluation");

endmodule

// ===== hdl/neighbor_table_with_aging_top.sv =====
// Top level of the neighbor table with per-channel timestamp aging.
`timescale 1ns / 1ps

// Usage:
//   Requests enter on request when start is high and busy is low. Each
//   request yields one result on result, marked by done for one cycle.
//   The receiver cannot hold results off.
//   cfg_we/cfg_wdata write max_age at any edge; write it while idle.
// Request flow:
//   Beacon: accept, id lookup and priority encode with the stamp row
//   read, then row update, busy high after the accept; result in the
//   cycle after the row update.
//   Sweep: one stamp row is read from the row memory per cycle and
//   checked in the next cycle, so the memory read port sets the rate.
//   Unused code or channel out of range: occupancy only.
//   A new request may start in the cycle its predecessor's result shows.
// Reset:
//   All entries and stamps become invalid, max_age returns to 1000,
//   no result is pending. No clearing pass is needed.
module neighbor_table_with_aging_top #(
    parameter int ENTRIES  = 64,
    parameter int CHANNELS = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  nta_pkg::request_t           request,
    input  logic                        cfg_we,
    input  logic [nta_pkg::TIME_W-1:0]  cfg_wdata,
    output logic                        done,
    output nta_pkg::result_t            result
);
    import nta_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencer
    nta_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (request.operation),
        .status    (status),
        .busy      (busy),
        .cmd       (cmd)
    );

    // Table and arithmetic
    nta_dp #(
        .ENTRIES  (ENTRIES),
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .status    (status),
        .done      (done),
        .result    (result)
    );

endmodule

// ===== sim/tb.sv =====
// Testbench for the neighbor table with aging: directed and random requests, self-checking.
`timescale 1ns / 1ps

module tb;

    import nta_pkg::*;

    localparam int ENTRIES   = 64;
    localparam int CHANNELS  = 4;
    localparam int POOL_SIZE = 80;

    // Operation code with no function in the block
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                start     = 1'b0;
    request_t            req       = '0;
    logic                cfg_we    = 1'b0;
    logic [TIME_W-1:0]   cfg_wdata = '0;
    logic                busy;
    logic                done;
    result_t             rsp;

    // Shadow copy of the table contents and the age register
    bit                  tbl_used     [ENTRIES];
    logic [ID_W-1:0]     tbl_id       [ENTRIES];
    logic [TIME_W-1:0]   tbl_stamp    [ENTRIES][CHANNELS];
    bit                  tbl_stamp_ok [ENTRIES][CHANNELS];
    logic [TIME_W-1:0]   age_limit    = MAX_AGE_RST;

    result_t             pending_results[$];
    logic [ID_W-1:0]     id_pool [POOL_SIZE];
    logic [TIME_W-1:0]   beacon_clock = '0;

    int n_sent     = 0;
    int n_beacon   = 0;
    int n_insert   = 0;
    int n_interval = 0;
    int n_full     = 0;
    int n_sweep    = 0;
    int n_removed  = 0;
    int n_checked  = 0;
    int err_count  = 0;

    neighbor_table_with_aging_top #(
        .ENTRIES  (ENTRIES),
        .CHANNELS (CHANNELS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (rsp)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Apply one request to the shadow table and return the result it should give
    function automatic result_t predict_table_op(request_t rq);
        result_t           res;
        int                occ;
        int                removed;
        int                hit;
        int                free_slot;
        bit                fresh;
        logic [TIME_W-1:0] limit;
        logic [TIME_W-1:0] elapsed;
        res = '0;
        occ = 0;
        for (int e = 0; e < ENTRIES; e++)
            if (tbl_used[e])
                occ++;
        res.occupancy_before = occ[CNT_W-1:0];
        if (rq.operation == OP_SWEEP_CFG || rq.operation == OP_SWEEP_AGE)
        begin
            limit   = (rq.operation == OP_SWEEP_CFG) ? age_limit : rq.sweep_age;
            removed = 0;
            for (int e = 0; e < ENTRIES; e++)
            begin
                if (!tbl_used[e])
                    continue;
                fresh = 1'b0;
                for (int c = 0; c < CHANNELS; c++)
                begin
                    elapsed = rq.now_time - tbl_stamp[e][c];
                    if (tbl_stamp_ok[e][c] && elapsed <= limit)
                        fresh = 1'b1;
                end
                if (!fresh)
                begin
                    tbl_used[e] = 1'b0;
                    for (int c = 0; c < CHANNELS; c++)
                        tbl_stamp_ok[e][c] = 1'b0;
                    removed++;
                end
            end
            res.removed_count = removed[CNT_W-1:0];
        end
        else if (rq.operation == OP_BEACON && rq.channel < CHANNELS)
        begin
            hit       = -1;
            free_slot = -1;
            for (int e = 0; e < ENTRIES; e++)
            begin
                if (tbl_used[e])
                begin
                    if (hit < 0 && tbl_id[e] == rq.vehicle_id)
                        hit = e;
                end
                else if (free_slot < 0)
                begin
                    free_slot = e;
                end
            end
            if (hit >= 0)
            begin
                // known neighbor: report interval, restamp this channel only
                if (tbl_stamp_ok[hit][rq.channel])
                begin
                    res.interval_valid = 1'b1;
                    res.interval       = rq.now_time - tbl_stamp[hit][rq.channel];
                end
                tbl_stamp[hit][rq.channel]    = rq.now_time;
                tbl_stamp_ok[hit][rq.channel] = 1'b1;
            end
            else if (free_slot >= 0)
            begin
                // new neighbor goes to the lowest free slot
                tbl_used[free_slot] = 1'b1;
                tbl_id[free_slot]   = rq.vehicle_id;
                for (int c = 0; c < CHANNELS; c++)
                    tbl_stamp_ok[free_slot][c] = 1'b0;
                tbl_stamp[free_slot][rq.channel]    = rq.now_time;
                tbl_stamp_ok[free_slot][rq.channel] = 1'b1;
                res.is_new = 1'b1;
            end
            else
            begin
                res.table_full = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic request_t make_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                              logic [CHAN_W-1:0] ch, logic [TIME_W-1:0] now,
                                              logic [TIME_W-1:0] age);
        request_t rq;
        rq.operation  = op;
        rq.vehicle_id = id;
        rq.channel    = ch;
        rq.now_time   = now;
        rq.sweep_age  = age;
        return rq;
    endfunction

    // Age limit for a register write: extremes, full range, or a useful middle
    function automatic logic [TIME_W-1:0] pick_age();
        logic [TIME_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = '1;
            2:       v = $urandom;
            default: v = $urandom_range(200, 3000);
        endcase
        return v;
    endfunction

    // Mostly beacons from a reused id pool so entries get hit, refreshed and aged out
    function automatic request_t random_request();
        request_t rq;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 72)
            rq.operation = OP_BEACON;
        else if (pick < 84)
            rq.operation = OP_SWEEP_CFG;
        else if (pick < 96)
            rq.operation = OP_SWEEP_AGE;
        else
            rq.operation = OP_UNUSED;
        if ($urandom_range(0, 9) == 0)
            rq.vehicle_id = ID_W'($urandom);
        else
            rq.vehicle_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        rq.channel = CHAN_W'($urandom_range(0, CHANNELS - 1));
        if ($urandom_range(0, 199) == 0)
            beacon_clock += $urandom;
        else
            beacon_clock += $urandom_range(0, 50);
        // now and then time steps backward
        if ($urandom_range(0, 49) == 0)
            rq.now_time = beacon_clock - $urandom_range(1, 100);
        else
            rq.now_time = beacon_clock;
        if ($urandom_range(0, 7) == 0)
            rq.sweep_age = $urandom;
        else
            rq.sweep_age = $urandom_range(0, 3000);
        return rq;
    endfunction

    // Present one request and hold it until accepted
    task automatic send_request(request_t rq);
        result_t want;
        start <= 1'b1;
        req   <= rq;
        do
            @(posedge clk);
        while (busy);
        want = predict_table_op(rq);
        pending_results.push_back(want);
        n_sent++;
        if (rq.operation == OP_BEACON)
            n_beacon++;
        if (rq.operation == OP_SWEEP_CFG || rq.operation == OP_SWEEP_AGE)
            n_sweep++;
        n_insert   += want.is_new;
        n_interval += want.interval_valid;
        n_full     += want.table_full;
        n_removed  += want.removed_count;
    endtask

    task automatic idle_cycles(int n);
        start <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Hold off until every outstanding result has come back
    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Only called while the block is idle
    task automatic write_max_age(logic [TIME_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        age_limit = v;
    endtask

    task automatic reset_dut();
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
    endtask

    // Field extremes, every operation, wrap of the interval, sweep boundaries
    task automatic test_directed();
        send_request(make_request(OP_SWEEP_CFG, 16'h0000, 2'd0, 32'd0, 32'd0));
        send_request(make_request(OP_BEACON, 16'h0000, 2'd0, 32'd0, 32'd0));
        send_request(make_request(OP_BEACON, 16'h0000, 2'd0, 32'd5, 32'hFFFF_FFFF));
        // second channel of a known id has no stamp yet
        send_request(make_request(OP_BEACON, 16'h0000, 2'd1, 32'd7, 32'd0));
        send_request(make_request(OP_BEACON, 16'hFFFF, 2'd3, 32'hFFFF_FFFF, 32'd0));
        // interval across the time wrap
        send_request(make_request(OP_BEACON, 16'hFFFF, 2'd3, 32'd10, 32'd0));
        send_request(make_request(OP_BEACON, 16'hFFFF, 2'd2, 32'd20, 32'd0));
        send_request(make_request(OP_UNUSED, 16'hFFFF, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_request(OP_SWEEP_AGE, 16'hFFFF, 2'd3, 32'd0, 32'hFFFF_FFFF));
        // zero age: only a stamp taken at exactly now survives
        send_request(make_request(OP_SWEEP_AGE, 16'h0000, 2'd0, 32'd10, 32'd0));
        // default limit of 1000: edge kept, one past removed
        send_request(make_request(OP_BEACON, 16'h1234, 2'd1, 32'd100, 32'd0));
        send_request(make_request(OP_SWEEP_CFG, 16'h0000, 2'd0, 32'd1100, 32'd0));
        send_request(make_request(OP_SWEEP_CFG, 16'h0000, 2'd0, 32'd1101, 32'd0));
        send_request(make_request(OP_BEACON, 16'hA5A5, 2'd2, 32'hAAAA_AAAA, 32'h5555_5555));
        send_request(make_request(OP_BEACON, 16'h5A5A, 2'd1, 32'h5555_5555, 32'hAAAA_AAAA));
        beacon_clock = 32'h5555_5555;
    endtask

    // Register at its extremes: a zero limit swept on both sides of it, an all-ones limit swept once
    task automatic test_config();
        wait_drained();
        write_max_age('0);
        send_request(make_request(OP_BEACON, 16'h0042, 2'd0, 32'd5000, 32'd0));
        send_request(make_request(OP_SWEEP_CFG, 16'h0000, 2'd0, 32'd5000, 32'd0));
        send_request(make_request(OP_SWEEP_CFG, 16'h0000, 2'd0, 32'd5001, 32'd0));
        wait_drained();
        write_max_age('1);
        send_request(make_request(OP_BEACON, 16'h0043, 2'd3, 32'd7000, 32'd0));
        send_request(make_request(OP_SWEEP_CFG, 16'h0000, 2'd0, 32'h8000_1B58, 32'd0));
        wait_drained();
        write_max_age(32'd2000);
        beacon_clock = 32'h8000_2000;
    endtask

    // Fill every entry, overflow with new ids, then hit a stored one
    task automatic test_table_full();
        beacon_clock += 32'd1_000_000;
        send_request(make_request(OP_SWEEP_AGE, 16'h0000, 2'd0, beacon_clock, 32'd0));
        for (int i = 0; i < ENTRIES + 3; i++)
        begin
            beacon_clock += 3;
            send_request(make_request(OP_BEACON, ID_W'(16'h8000 + i * 3), CHAN_W'(i),
                                      beacon_clock, 32'd0));
        end
        send_request(make_request(OP_BEACON, 16'h8000, 2'd1, beacon_clock, 32'd0));
        send_request(make_request(OP_BEACON, 16'h8000, 2'd0, beacon_clock + 9, 32'd0));
        send_request(make_request(OP_SWEEP_CFG, 16'h0000, 2'd0, beacon_clock + 2100, 32'd0));
    endtask

    // Random traffic in batches; register rewritten between some batches, no gaps at the end
    task automatic test_random(int batches);
        bit quiet;
        for (int i = 0; i < POOL_SIZE; i++)
            id_pool[i] = ID_W'($urandom);
        id_pool[0]   = '0;
        id_pool[1]   = '1;
        beacon_clock = 32'hFFFF_8000;
        for (int b = 0; b < batches; b++)
        begin
            quiet = (b >= batches - batches / 6);
            if (!quiet && b % 12 == 11)
            begin
                wait_drained();
                write_max_age(pick_age());
            end
            for (int i = 0; i < 8; i++)
            begin
                if (!quiet && b % 3 != 0 && $urandom_range(0, 3) == 0)
                    idle_cycles($urandom_range(1, 10));
                send_request(random_request());
            end
        end
    endtask

    task automatic check_field(string fname, logic [TIME_W-1:0] want, logic [TIME_W-1:0] got);
        if (want !== got)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
        end
    endtask

    // Compare each result with the oldest outstanding prediction
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                err_count++;
                $display("%0t: result with none expected, expected nothing, actual %h",
                         $time, rsp);
            end
            else
            begin
                want = pending_results.pop_front();
                n_checked++;
                check_field("is_new", want.is_new, rsp.is_new);
                check_field("table_full", want.table_full, rsp.table_full);
                check_field("interval_valid", want.interval_valid, rsp.interval_valid);
                check_field("interval", want.interval, rsp.interval);
                check_field("occupancy_before", want.occupancy_before, rsp.occupancy_before);
                check_field("removed_count", want.removed_count, rsp.removed_count);
            end
        end
    end

    initial
    begin
        reset_dut();
        test_directed();
        test_config();
        test_table_full();
        wait_drained();
        test_random(90);
        wait_drained();
        repeat (10) @(posedge clk);
        $display("Ran %0d requests: %0d beacons (%0d inserted, %0d with interval, %0d dropped full)",
                 n_sent, n_beacon, n_insert, n_interval, n_full);
        $display("%0d sweeps removed %0d entries; %0d results checked, %0d errors",
                 n_sweep, n_removed, n_checked, err_count);
        if (err_count == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5ms;
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("status: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/nta_pkg.sv
hdl/nta_ctrl.sv
hdl/nta_dp.sv
hdl/neighbor_table_with_aging_top.sv
sim/tb.sv
